// ===== sv/tpcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpcd_pkg
// Shared constants, register indexes, flag struct and width helpers for the
// triangle coverage and plane depth pipeline.
// ----------------------------------------------------------------------------
package tpcd_pkg;

  localparam int REG_WIDTH       = 48;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int PIXEL_WIDTH     = 16;
  localparam int DEPTH_OUT_WIDTH = 16;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int DEPTH_WIDTH_DEF = 16;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_VERTEX0 = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_VERTEX1 = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_VERTEX2 = 2'd2;

  // Status that travels with each pixel through the pipeline.
  typedef struct packed {
    logic edge_ok;  // the edge functions of all three sides are nonnegative
    logic degen;    // plane normal has a zero z component
    logic neg;      // quotient is negative
    logic ovf;      // quotient magnitude is at or above the clamp limit
  } tpcd_flags_t;

  // Width of a pixel-minus-vertex difference.
  function automatic int dx_width(int cw);
    return ((cw > PIXEL_WIDTH) ? cw : PIXEL_WIDTH) + 1;
  endfunction

  // Width of the nx and ny normal components.
  function automatic int nxy_width(int cw, int dw);
    return (dw + 1) + (cw + 1) + 1;
  endfunction

  // Width of the nz normal component (the divisor).
  function automatic int den_width(int cw);
    return 2 * (cw + 1) + 1;
  endfunction

  // Width of the plane numerator nx*dx + ny*dy.
  function automatic int num_width(int cw, int dw);
    return nxy_width(cw, dw) + dx_width(cw) + 1;
  endfunction

  // Quotient bits that are resolved; larger magnitudes always saturate.
  function automatic int quot_width(int dw);
    return dw + 1;
  endfunction

endpackage

`default_nettype wire

// ===== sv/tpcd_pixel_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpcd_pixel_if
// Pixel position channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tpcd_pixel_if
  import tpcd_pkg::*;
();

  logic                          valid;
  logic                          ready;
  logic signed [PIXEL_WIDTH-1:0] pixel_x;
  logic signed [PIXEL_WIDTH-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);

endinterface

`default_nettype wire

// ===== sv/tpcd_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpcd_result_if
// Coverage and depth result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tpcd_result_if
  import tpcd_pkg::*;
();

  logic                              valid;
  logic                              ready;
  logic                              covered;
  logic signed [DEPTH_OUT_WIDTH-1:0] depth;
  logic                              degenerate;

  modport source (output valid, output covered, output depth, output degenerate,
                  input ready);
  modport sink   (input valid, input covered, input depth, input degenerate,
                  output ready);

endinterface

`default_nettype wire

// ===== sv/triangle_pixel_coverage_depth.sv =====
// Pipeline from pixel transfer to result:
//   three front stages, DEPTH_WIDTH + 2 divider stages, one output register.
// Throughput: one pixel per clock unless stalled; one quotient bit per g_bit stage.
// Reset (rst, synchronous, active high) empties the pipeline and clears all
//   three vertex registers to zero.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_pixel_coverage_depth
// Per-pixel edge function coverage test against one triangle and plane
// interpolated depth, fully pipelined.
// ----------------------------------------------------------------------------
//
// The triangle lives in three vertex registers, each packing x and y (signed
// 12.4 at the defaults) and depth (signed Q2.14). Software must write them
// only while the pipeline is empty; the block itself does not enforce it.
// Stage 1 and the out stage read them live, so the setup (edge vectors and
// the plane normal) is redone per pixel with the pixel math, not latched.
//
// Pipeline structure:
//   front   Stage 1 forms the six products for the edges and the six normal products.
//           Stage 2 forms the edge functions and their signs, the normal
//           components, and multiplies nx and ny by the pixel offsets.
//           Stage 3 sums the numerator and splits numerator and nz into sign
//           and magnitude.
//   div     A restoring divider. Its first stage checks whether the quotient
//           magnitude reaches 2^(DEPTH_WIDTH+1); any such quotient saturates
//           the depth, so only DEPTH_WIDTH+1 quotient bits are resolved, one
//           per stage. Truncation toward zero falls out of dividing
//           magnitudes and applying the sign afterwards.
//   out     Applies the sign, subtracts from the first vertex depth,
//           saturates, and holds the result in the output register.
//
// Every stage has its own valid bit and moves when it is empty or when the
// stage after it moves, so bubbles are squeezed out and the input keeps
// taking transfers while a result waits at the output, until the stages fill.
//
// A triangle whose normal has a zero z component is degenerate: it reports
// degenerate, never covered, and depth zero.
module triangle_pixel_coverage_depth
  import tpcd_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int DEPTH_WIDTH = DEPTH_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [REG_WIDTH-1:0]       cfg_wdata,
  tpcd_pixel_if.sink                 pixel,
  tpcd_result_if.source              result
);

  localparam int NUMW = num_width(COORD_WIDTH, DEPTH_WIDTH);
  localparam int DENW = den_width(COORD_WIDTH);
  localparam int QB   = quot_width(DEPTH_WIDTH);
  localparam int LANEW = 2 * COORD_WIDTH + DEPTH_WIDTH;
  // Lane bits that fall above the register read as zero.
  localparam int EXTW = (LANEW > REG_WIDTH) ? LANEW : REG_WIDTH;

  // ---------------- vertex registers ----------------
  logic [REG_WIDTH-1:0] vertex0, vertex1, vertex2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex0 <= '0;
      vertex1 <= '0;
      vertex2 <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_VERTEX0: vertex0 <= cfg_wdata;
        REG_VERTEX1: vertex1 <= cfg_wdata;
        REG_VERTEX2: vertex2 <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- lane unpacking ----------------
  logic [EXTW-1:0] v0_ext, v1_ext, v2_ext;
  logic signed [COORD_WIDTH-1:0] x0, y0, x1, y1, x2, y2;
  logic signed [DEPTH_WIDTH-1:0] z0, z1, z2;

  assign v0_ext = EXTW'(vertex0);
  assign v1_ext = EXTW'(vertex1);
  assign v2_ext = EXTW'(vertex2);

  assign x0 = v0_ext[COORD_WIDTH-1:0];
  assign y0 = v0_ext[2*COORD_WIDTH-1:COORD_WIDTH];
  assign z0 = v0_ext[LANEW-1:2*COORD_WIDTH];
  assign x1 = v1_ext[COORD_WIDTH-1:0];
  assign y1 = v1_ext[2*COORD_WIDTH-1:COORD_WIDTH];
  assign z1 = v1_ext[LANEW-1:2*COORD_WIDTH];
  assign x2 = v2_ext[COORD_WIDTH-1:0];
  assign y2 = v2_ext[2*COORD_WIDTH-1:COORD_WIDTH];
  assign z2 = v2_ext[LANEW-1:2*COORD_WIDTH];

  // ---------------- front end: edges and plane numerator ----------------
  logic            front_valid, front_ready;
  logic [NUMW-1:0] num_mag;
  logic [DENW-1:0] den_mag;
  tpcd_flags_t     front_flags;

  tpcd_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .DEPTH_WIDTH (DEPTH_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .x0        (x0),
    .y0        (y0),
    .x1        (x1),
    .y1        (y1),
    .x2        (x2),
    .y2        (y2),
    .z0        (z0),
    .z1        (z1),
    .z2        (z2),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .pixel_x   (pixel.pixel_x),
    .pixel_y   (pixel.pixel_y),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .num_mag   (num_mag),
    .den_mag   (den_mag),
    .flags     (front_flags)
  );

  // ---------------- divider ----------------
  logic          div_valid, div_ready;
  logic [QB-1:0] quot;
  tpcd_flags_t   div_flags;

  tpcd_div #(
    .COORD_WIDTH (COORD_WIDTH),
    .DEPTH_WIDTH (DEPTH_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .num_mag   (num_mag),
    .den_mag   (den_mag),
    .flags_in  (front_flags),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .quot      (quot),
    .flags_out (div_flags)
  );

  // ---------------- depth and output register ----------------
  tpcd_out #(
    .DEPTH_WIDTH (DEPTH_WIDTH)
  ) u_out (
    .clk        (clk),
    .rst        (rst),
    .z0         (z0),
    .in_valid   (div_valid),
    .in_ready   (div_ready),
    .quot       (quot),
    .flags      (div_flags),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .covered    (result.covered),
    .depth      (result.depth),
    .degenerate (result.degenerate)
  );

endmodule

`default_nettype wire

// ===== sv/tpcd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpcd_front
// Three pipeline stages: edge and normal products, edge signs and numerator
// products, then numerator sum and sign-magnitude split for the divider.
// ----------------------------------------------------------------------------
module tpcd_front
  import tpcd_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int DEPTH_WIDTH = DEPTH_WIDTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic signed [COORD_WIDTH-1:0]              x0,
  input  logic signed [COORD_WIDTH-1:0]              y0,
  input  logic signed [COORD_WIDTH-1:0]              x1,
  input  logic signed [COORD_WIDTH-1:0]              y1,
  input  logic signed [COORD_WIDTH-1:0]              x2,
  input  logic signed [COORD_WIDTH-1:0]              y2,
  input  logic signed [DEPTH_WIDTH-1:0]              z0,
  input  logic signed [DEPTH_WIDTH-1:0]              z1,
  input  logic signed [DEPTH_WIDTH-1:0]              z2,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic signed [PIXEL_WIDTH-1:0]              pixel_x,
  input  logic signed [PIXEL_WIDTH-1:0]              pixel_y,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic [num_width(COORD_WIDTH, DEPTH_WIDTH)-1:0] num_mag,
  output logic [den_width(COORD_WIDTH)-1:0]          den_mag,
  output tpcd_flags_t                                flags
);

  localparam int DXW  = dx_width(COORD_WIDTH);
  localparam int CDW  = COORD_WIDTH + 1;
  localparam int ZDW  = DEPTH_WIDTH + 1;
  localparam int EPW  = DXW + CDW;
  localparam int EW   = EPW + 1;
  localparam int SPW  = ZDW + CDW;
  localparam int NW   = nxy_width(COORD_WIDTH, DEPTH_WIDTH);
  localparam int ZPW  = 2 * CDW;
  localparam int DENW = den_width(COORD_WIDTH);
  localparam int NPW  = NW + DXW;
  localparam int NUMW = num_width(COORD_WIDTH, DEPTH_WIDTH);

  logic en1, en2, en3;
  logic v1, v2, v3;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign out_valid = v3;

  // ---------------- stage 1: products ----------------
  logic signed [COORD_WIDTH-1:0] xv [3];
  logic signed [COORD_WIDTH-1:0] yv [3];
  logic signed [EPW-1:0]         ea_next [3];
  logic signed [EPW-1:0]         eb_next [3];
  logic signed [EPW-1:0]         ea [3];
  logic signed [EPW-1:0]         eb [3];

  assign xv[0] = x0;
  assign xv[1] = x1;
  assign xv[2] = x2;
  assign yv[0] = y0;
  assign yv[1] = y1;
  assign yv[2] = y2;

  genvar k;
  for (k = 0; k < 3; k++) begin : g_edge
    localparam int J = (k == 2) ? 0 : k + 1;
    logic signed [DXW-1:0] dvx;
    logic signed [DXW-1:0] dvy;
    logic signed [CDW-1:0] ex;
    logic signed [CDW-1:0] ey;
    assign dvx = DXW'(pixel_x) - DXW'(xv[k]);
    assign dvy = DXW'(pixel_y) - DXW'(yv[k]);
    assign ex  = CDW'(xv[J]) - CDW'(xv[k]);
    assign ey  = CDW'(yv[J]) - CDW'(yv[k]);
    assign ea_next[k] = EPW'(dvx) * EPW'(ey);
    assign eb_next[k] = EPW'(dvy) * EPW'(ex);
  end

  logic signed [DXW-1:0] dx0_next, dy0_next, dx0, dy0;
  logic signed [CDW-1:0] ax, ay, bx, by;
  logic signed [ZDW-1:0] az, bz;
  logic signed [SPW-1:0] sp_next [4];
  logic signed [SPW-1:0] sp [4];
  logic signed [ZPW-1:0] zp_next [2];
  logic signed [ZPW-1:0] zp [2];

  assign dx0_next = DXW'(pixel_x) - DXW'(x0);
  assign dy0_next = DXW'(pixel_y) - DXW'(y0);
  assign ax = CDW'(x1) - CDW'(x0);
  assign ay = CDW'(y1) - CDW'(y0);
  assign bx = CDW'(x2) - CDW'(x0);
  assign by = CDW'(y2) - CDW'(y0);
  assign az = ZDW'(z1) - ZDW'(z0);
  assign bz = ZDW'(z2) - ZDW'(z0);

  assign sp_next[0] = SPW'(az) * SPW'(by);
  assign sp_next[1] = SPW'(ay) * SPW'(bz);
  assign sp_next[2] = SPW'(ax) * SPW'(bz);
  assign sp_next[3] = SPW'(az) * SPW'(bx);
  assign zp_next[0] = ZPW'(ay) * ZPW'(bx);
  assign zp_next[1] = ZPW'(ax) * ZPW'(by);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < 3; i++) begin
        ea[i] <= ea_next[i];
        eb[i] <= eb_next[i];
      end
      for (int i = 0; i < 4; i++) begin
        sp[i] <= sp_next[i];
      end
      zp[0] <= zp_next[0];
      zp[1] <= zp_next[1];
      dx0   <= dx0_next;
      dy0   <= dy0_next;
    end
  end

  // ---------------- stage 2: edge signs, numerator products ----------------
  logic signed [EW-1:0]   e [3];
  logic                   edge_ok_next, edge_ok;
  logic signed [NW-1:0]   nx, ny;
  logic signed [NPW-1:0]  nxp_next, nyp_next, nxp, nyp;
  logic signed [DENW-1:0] nz_next, nz;

  always_comb begin
    edge_ok_next = 1'b1;
    for (int i = 0; i < 3; i++) begin
      e[i] = EW'(ea[i]) - EW'(eb[i]);
      edge_ok_next = edge_ok_next & !e[i][EW-1];
    end
  end

  assign nx       = NW'(sp[0]) - NW'(sp[1]);
  assign ny       = NW'(sp[2]) - NW'(sp[3]);
  assign nxp_next = NPW'(nx) * NPW'(dx0);
  assign nyp_next = NPW'(ny) * NPW'(dy0);
  assign nz_next  = DENW'(zp[0]) - DENW'(zp[1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      edge_ok <= edge_ok_next;
      nxp     <= nxp_next;
      nyp     <= nyp_next;
      nz      <= nz_next;
    end
  end

  // ---------------- stage 3: numerator sum, sign and magnitude ----------------
  logic signed [NUMW-1:0] num;
  logic [NUMW-1:0]        num_abs;
  logic [DENW-1:0]        den_abs;
  tpcd_flags_t            flags_next;

  assign num     = NUMW'(nxp) + NUMW'(nyp);
  assign num_abs = num[NUMW-1] ? $unsigned(-num) : $unsigned(num);
  assign den_abs = nz[DENW-1] ? $unsigned(-nz) : $unsigned(nz);

  always_comb begin
    flags_next.edge_ok = edge_ok;
    flags_next.degen   = (nz == '0);
    flags_next.neg     = num[NUMW-1] ^ nz[DENW-1];
    flags_next.ovf     = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      num_mag <= num_abs;
      den_mag <= den_abs;
      flags   <= flags_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tpcd_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpcd_div
// Pipelined restoring divider on magnitudes: a range check stage, then one
// quotient bit per stage, most significant first.
// ----------------------------------------------------------------------------
module tpcd_div
  import tpcd_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int DEPTH_WIDTH = DEPTH_WIDTH_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           in_valid,
  output logic                                           in_ready,
  input  logic [num_width(COORD_WIDTH, DEPTH_WIDTH)-1:0] num_mag,
  input  logic [den_width(COORD_WIDTH)-1:0]              den_mag,
  input  tpcd_flags_t                                    flags_in,
  output logic                                           out_valid,
  input  logic                                           out_ready,
  output logic [quot_width(DEPTH_WIDTH)-1:0]             quot,
  output tpcd_flags_t                                    flags_out
);

  localparam int NUMW = num_width(COORD_WIDTH, DEPTH_WIDTH);
  localparam int DENW = den_width(COORD_WIDTH);
  localparam int QB   = quot_width(DEPTH_WIDTH);
  localparam int RW   = (NUMW > DENW + QB + 1) ? NUMW : DENW + QB + 1;
  localparam int NS   = QB + 1;

  logic [RW-1:0]   r_q [NS];
  logic [DENW-1:0] d_q [NS];
  logic [QB-1:0]   q_q [NS];
  tpcd_flags_t     f_q [NS];
  logic [NS-1:0]   v_q;
  logic [NS-1:0]   en;

  genvar s;
  for (s = 0; s < NS; s++) begin : g_stage
    localparam int SH = (s == 0) ? QB : QB - s;

    logic [RW-1:0]   src_r;
    logic [DENW-1:0] src_d;
    logic [QB-1:0]   src_q;
    tpcd_flags_t     src_f;
    logic            src_v;
    logic [RW-1:0]   dsh;
    logic            ge;
    logic [RW-1:0]   r_next;
    logic [QB-1:0]   q_next;
    tpcd_flags_t     f_next;

    if (s == 0) begin : g_first
      assign src_r = RW'(num_mag);
      assign src_d = den_mag;
      assign src_q = '0;
      assign src_f = flags_in;
      assign src_v = in_valid;
    end else begin : g_next
      assign src_r = r_q[s-1];
      assign src_d = d_q[s-1];
      assign src_q = q_q[s-1];
      assign src_f = f_q[s-1];
      assign src_v = v_q[s-1];
    end

    if (s == NS - 1) begin : g_last_en
      assign en[s] = !v_q[s] || out_ready;
    end else begin : g_mid_en
      assign en[s] = !v_q[s] || en[s+1];
    end

    assign dsh = RW'(src_d) << SH;
    assign ge  = (src_r >= dsh);

    if (s == 0) begin : g_range
      // Flags a quotient too large to matter: the depth saturates anyway.
      always_comb begin
        r_next     = src_r;
        q_next     = src_q;
        f_next     = src_f;
        f_next.ovf = ge;
      end
    end else begin : g_bit
      always_comb begin
        r_next     = ge ? (src_r - dsh) : src_r;
        q_next     = src_q;
        q_next[SH] = ge;
        f_next     = src_f;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[s] <= 1'b0;
      end else if (en[s]) begin
        v_q[s] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        r_q[s] <= r_next;
        d_q[s] <= src_d;
        q_q[s] <= q_next;
        f_q[s] <= f_next;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_q[NS-1];
  assign quot      = q_q[NS-1];
  assign flags_out = f_q[NS-1];

endmodule

`default_nettype wire

// ===== sv/tpcd_out.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpcd_out
// Final stage: signs the quotient, subtracts it from the first vertex depth,
// saturates, and holds the result in the output register.
// ----------------------------------------------------------------------------
module tpcd_out
  import tpcd_pkg::*;
#(
  parameter int DEPTH_WIDTH = DEPTH_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic signed [DEPTH_WIDTH-1:0]      z0,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [quot_width(DEPTH_WIDTH)-1:0] quot,
  input  tpcd_flags_t                        flags,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               covered,
  output logic signed [DEPTH_OUT_WIDTH-1:0]  depth,
  output logic                               degenerate
);

  localparam int QB = quot_width(DEPTH_WIDTH);
  localparam int ZW = QB + 3;
  localparam int OW = (DEPTH_WIDTH > DEPTH_OUT_WIDTH) ? DEPTH_WIDTH : DEPTH_OUT_WIDTH;
  localparam logic signed [ZW-1:0] ZHI =
    {{(ZW - DEPTH_WIDTH + 1){1'b0}}, {(DEPTH_WIDTH - 1){1'b1}}};
  localparam logic signed [ZW-1:0] ZLO = ~ZHI;

  logic                          en;
  logic [QB:0]                   qc;
  logic signed [QB+1:0]          qs;
  logic signed [ZW-1:0]          z;
  logic signed [DEPTH_WIDTH-1:0] sat;
  logic signed [OW-1:0]          sat_w;
  logic signed [DEPTH_OUT_WIDTH-1:0] depth_next;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  // A clamped magnitude of 2^QB already pushes the depth past either limit.
  assign qc = flags.ovf ? {1'b1, {QB{1'b0}}} : {1'b0, quot};
  assign qs = flags.neg ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
  assign z  = ZW'(z0) - ZW'(qs);

  always_comb begin
    if (z > ZHI) begin
      sat = ZHI[DEPTH_WIDTH-1:0];
    end else if (z < ZLO) begin
      sat = ZLO[DEPTH_WIDTH-1:0];
    end else begin
      sat = z[DEPTH_WIDTH-1:0];
    end
  end

  assign sat_w      = OW'(sat);
  assign depth_next = flags.degen ? '0 : sat_w[DEPTH_OUT_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      covered    <= flags.edge_ok & !flags.degen;
      depth      <= depth_next;
      degenerate <= flags.degen;
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_triangle_pixel_coverage_depth.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_pixel_coverage_depth
// Self-checking bench for the triangle coverage and plane depth pipeline.
// It loads a series of triangles through the register port, streams pixel
// positions through the valid/ready channels with random bursts and stalls,
// and checks every result against an in-bench model of the edge tests and
// the plane depth.
// ----------------------------------------------------------------------------
module tb_triangle_pixel_coverage_depth;
  import tpcd_pkg::*;

  localparam int CLK_HALF         = 6;
  localparam int RESET_CYCLES     = 8;
  // Pixel transfer to result transfer, as given for the default widths.
  localparam int PIPE_LATENCY     = DEPTH_WIDTH_DEF + 6;
  // The longest quiet stretch of a correct run is a drain: the pipeline
  // latency plus a receiver stall. WATCHDOG_LIMIT is far beyond that.
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int RANDOM_TRIANGLES = 64;
  localparam int REPORT_LIMIT     = 10;
  localparam longint DEPTH_MAX    = (longint'(1) << (DEPTH_OUT_WIDTH - 1)) - 1;
  localparam longint DEPTH_MIN    = -DEPTH_MAX - 1;

  // How the result side applies back-pressure during one triangle.
  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_PATTERN,
    READY_MOSTLY,
    READY_SPARSE
  } ready_mode_t;

  typedef struct packed {
    logic                       covered;
    logic [DEPTH_OUT_WIDTH-1:0] depth;
    logic                       degenerate;
  } pixel_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard. It keeps its own copy of the three vertex registers, turns
  // every accepted pixel into the expected coverage and depth, and checks the
  // results in order against that queue.
  // --------------------------------------------------------------------------
  class depth_scoreboard;
    logic [REG_WIDTH-1:0] vertex [3];
    pixel_result_t        pending_results [$];
    int checked;
    int mismatches;
    int covered_predicted;
    int degenerate_predicted;
    int saturated_predicted;

    function new();
      for (int i = 0; i < 3; i++) vertex[i] = '0;
      checked              = 0;
      mismatches           = 0;
      covered_predicted    = 0;
      degenerate_predicted = 0;
      saturated_predicted  = 0;
    endfunction

    function void load_vertex(logic [CFG_INDEX_WIDTH-1:0] index, logic [REG_WIDTH-1:0] value);
      case (index)
        REG_VERTEX0: vertex[0] = value;
        REG_VERTEX1: vertex[1] = value;
        REG_VERTEX2: vertex[2] = value;
        default: ;
      endcase
    endfunction

    // Sign-extended field of a vertex word.
    function longint lane(logic [REG_WIDTH-1:0] word, int lsb, int width);
      longint v;
      v = longint'(word >> lsb);
      return (v << (64 - width)) >>> (64 - width);
    endfunction

    function longint edge_value(longint vx, vy, ix, iy, jx, jy);
      return (vx - ix) * (jy - iy) - (vy - iy) * (jx - ix);
    endfunction

    function pixel_result_t coverage_and_depth(longint px, longint py);
      longint        x [3];
      longint        y [3];
      longint        z [3];
      longint        ax, ay, az, bx, by, bz, nx, ny, nz;
      longint        plane_num, quot, z_pix;
      pixel_result_t r;
      for (int i = 0; i < 3; i++) begin
        x[i] = lane(vertex[i], 0, COORD_WIDTH_DEF);
        y[i] = lane(vertex[i], COORD_WIDTH_DEF, COORD_WIDTH_DEF);
        z[i] = lane(vertex[i], 2 * COORD_WIDTH_DEF, DEPTH_WIDTH_DEF);
      end
      r  = '0;
      ax = x[1] - x[0];
      ay = y[1] - y[0];
      az = z[1] - z[0];
      bx = x[2] - x[0];
      by = y[2] - y[0];
      bz = z[2] - z[0];
      nz = ay * bx - ax * by;
      if (nz == 0) begin
        r.degenerate = 1'b1;
        degenerate_predicted++;
      end else begin
        nx        = az * by - ay * bz;
        ny        = ax * bz - az * bx;
        plane_num = nx * (px - x[0]) + ny * (py - y[0]);
        // Division of signed longints truncates toward zero.
        quot  = plane_num / nz;
        z_pix = z[0] - quot;
        if (z_pix > DEPTH_MAX || z_pix < DEPTH_MIN) saturated_predicted++;
        if (z_pix > DEPTH_MAX) z_pix = DEPTH_MAX;
        if (z_pix < DEPTH_MIN) z_pix = DEPTH_MIN;
        r.depth   = z_pix[DEPTH_OUT_WIDTH-1:0];
        r.covered = edge_value(px, py, x[0], y[0], x[1], y[1]) >= 0 &&
                    edge_value(px, py, x[1], y[1], x[2], y[2]) >= 0 &&
                    edge_value(px, py, x[2], y[2], x[0], y[0]) >= 0;
        if (r.covered) covered_predicted++;
      end
      return r;
    endfunction

    function void note_pixel(logic signed [PIXEL_WIDTH-1:0] px, logic signed [PIXEL_WIDTH-1:0] py);
      pending_results.push_back(coverage_and_depth(px, py));
    endfunction

    function void check_result(logic covered, logic [DEPTH_OUT_WIDTH-1:0] depth,
                               logic degenerate);
      pixel_result_t want;
      if (pending_results.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("ERROR: result with no pixel pending: covered=%0b depth=%0d degenerate=%0b",
                   covered, $signed(depth), degenerate);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (want.covered !== covered || want.depth !== depth || want.degenerate !== degenerate)
      begin
        if (mismatches < REPORT_LIMIT)
          $display("ERROR: result %0d: expected covered=%0b depth=%0d degenerate=%0b, %s",
                   checked, want.covered, $signed(want.depth), want.degenerate,
                   $sformatf("got covered=%0b depth=%0d degenerate=%0b",
                             covered, $signed(depth), degenerate));
        mismatches++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test and its channels.
  // --------------------------------------------------------------------------
  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_wr_en;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [REG_WIDTH-1:0]       cfg_wdata;

  tpcd_pixel_if  pixel ();
  tpcd_result_if result ();

  triangle_pixel_coverage_depth dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pixel     (pixel),
    .result    (result)
  );

  depth_scoreboard sb;

  // The triangle currently being loaded by the random part.
  int corner_x [3];
  int corner_y [3];
  int corner_z [3];

  int          setups;
  int          idle_cycles;
  ready_mode_t ready_mode;
  logic [11:0] stall_pattern;
  int          stall_phase;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Result side back-pressure. The mode and the 12-bit stall pattern are
  // picked per triangle by the stimulus process; the pattern is never all
  // zeros, so a stall in that mode always ends within one turn of the pattern.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      stall_phase  <= 0;
    end else begin
      stall_phase <= (stall_phase == 11) ? 0 : stall_phase + 1;
      case (ready_mode)
        READY_ALWAYS:  result.ready <= 1'b1;
        READY_PATTERN: result.ready <= stall_pattern[stall_phase];
        READY_MOSTLY:  result.ready <= ($urandom_range(0, 3) != 0);
        default:       result.ready <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Register writes, pixel transfers and result transfers are all
  // observed at the clock edge where they take effect, so the scoreboard sees
  // exactly what the block saw. The same block runs the watchdog, which ends
  // the run after a long stretch with no transfer of any kind.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (cfg_wr_en) sb.load_vertex(cfg_index, cfg_wdata);
      if (pixel.valid && pixel.ready) sb.note_pixel(pixel.pixel_x, pixel.pixel_y);
      if (result.valid && result.ready)
        sb.check_result(result.covered, result.depth, result.degenerate);
      if (cfg_wr_en || (pixel.valid && pixel.ready) || (result.valid && result.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("ERROR: no transfer for %0d cycles, %0d results still pending",
                 WATCHDOG_LIMIT, sb.pending_results.size());
        $display("tb_triangle_pixel_coverage_depth failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks. Everything is driven with nonblocking assignments right
  // after a rising edge, and handshakes are sampled at the edge itself.
  // --------------------------------------------------------------------------
  function automatic logic [REG_WIDTH-1:0] pack_vertex(logic signed [15:0] x,
                                                       logic signed [15:0] y,
                                                       logic signed [15:0] z);
    return {z, y, x};
  endfunction

  // Loads all three vertex registers on back-to-back cycles. Only called
  // while the pipeline is empty, since the block reads the registers live.
  task automatic write_triangle(input logic [REG_WIDTH-1:0] v0, v1, v2);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_VERTEX0;
    cfg_wdata <= v0;
    @(posedge clk);
    cfg_index <= REG_VERTEX1;
    cfg_wdata <= v1;
    @(posedge clk);
    cfg_index <= REG_VERTEX2;
    cfg_wdata <= v2;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    setups++;
  endtask

  // Offers one pixel and returns at the edge of its transfer with valid still
  // high, so the next pixel of a burst follows without a bubble.
  task automatic send_pixel(input logic signed [PIXEL_WIDTH-1:0] px, py);
    pixel.valid   <= 1'b1;
    pixel.pixel_x <= px;
    pixel.pixel_y <= py;
    do @(posedge clk); while (!pixel.ready);
  endtask

  task automatic pixel_idle(input int cycles);
    pixel.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stops the pixel stream and waits for every outstanding result. The first
  // edge lets the monitor log the last pixel transfer before the queue is
  // looked at.
  task automatic drain_results();
    pixel.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic int rand_around(int center, int span);
    int v;
    v = center - span / 2 + int'($urandom_range(span));
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  // Random triangle. Most are small so that a good share of the pixels land
  // inside; a few span the whole coordinate range. About one in ten is made
  // degenerate, and most of the rest are put in the winding that can cover.
  task automatic make_random_triangle();
    int     span, cx, cy, sel, tmp;
    longint nz;
    sel = $urandom_range(0, 9);
    if (sel < 5) span = $urandom_range(16, 512);
    else if (sel < 8) span = 4096;
    else if (sel < 9) span = 16384;
    else span = 65535;
    cx = int'($urandom_range(0, 65535)) - 32768;
    cy = int'($urandom_range(0, 65535)) - 32768;
    for (int i = 0; i < 3; i++) begin
      corner_x[i] = rand_around(cx, span);
      corner_y[i] = rand_around(cy, span);
      if ($urandom_range(0, 1) == 0)
        corner_z[i] = int'($urandom_range(0, 65535)) - 32768;
      else
        corner_z[i] = rand_around(int'($urandom_range(0, 16383)) - 8192, 1024);
    end
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      // Two corners on the same spot.
      corner_x[2] = corner_x[1];
      corner_y[2] = corner_y[1];
    end else if (sel == 1) begin
      // All three corners on one horizontal line.
      corner_y[1] = corner_y[0];
      corner_y[2] = corner_y[0];
    end
    nz = longint'(corner_y[1] - corner_y[0]) * (corner_x[2] - corner_x[0]) -
         longint'(corner_x[1] - corner_x[0]) * (corner_y[2] - corner_y[0]);
    if (nz < 0 && $urandom_range(0, 4) != 0) begin
      tmp = corner_x[1]; corner_x[1] = corner_x[2]; corner_x[2] = tmp;
      tmp = corner_y[1]; corner_y[1] = corner_y[2]; corner_y[2] = tmp;
      tmp = corner_z[1]; corner_z[1] = corner_z[2]; corner_z[2] = tmp;
    end
  endtask

  // Pixels mostly fall in the bounding box of the current triangle; some hit
  // a corner exactly and the rest are anywhere in the 16-bit range.
  task automatic pick_pixel(output logic signed [PIXEL_WIDTH-1:0] px, py);
    int lo_x, hi_x, lo_y, hi_y, sel, k;
    lo_x = corner_x[0];
    hi_x = corner_x[0];
    lo_y = corner_y[0];
    hi_y = corner_y[0];
    for (int i = 1; i < 3; i++) begin
      if (corner_x[i] < lo_x) lo_x = corner_x[i];
      if (corner_x[i] > hi_x) hi_x = corner_x[i];
      if (corner_y[i] < lo_y) lo_y = corner_y[i];
      if (corner_y[i] > hi_y) hi_y = corner_y[i];
    end
    sel = $urandom_range(0, 19);
    if (sel < 15) begin
      px = lo_x + int'($urandom_range(hi_x - lo_x));
      py = lo_y + int'($urandom_range(hi_y - lo_y));
    end else if (sel < 17) begin
      k  = $urandom_range(0, 2);
      px = corner_x[k];
      py = corner_y[k];
    end else begin
      px = $urandom_range(0, 65535);
      py = $urandom_range(0, 65535);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin
    logic signed [PIXEL_WIDTH-1:0] px, py;
    int n_items, gap_max, burst_left, gap;

    sb     = new();
    setups = 0;

    rst           <= 1'b1;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= REG_VERTEX0;
    cfg_wdata     <= '0;
    pixel.valid   <= 1'b0;
    pixel.pixel_x <= '0;
    pixel.pixel_y <= '0;
    ready_mode    <= READY_ALWAYS;
    stall_pattern <= '1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Out of reset all three vertices sit at the origin, so every pixel must
    // come back degenerate with zero depth, whatever its position.
    send_pixel(0, 0);
    send_pixel(-32768, 32767);
    send_pixel(32767, -32768);
    drain_results();

    // A right triangle in the covering winding. The pixels hit a corner, the
    // hypotenuse, the interior, just outside and the far corners of the
    // pixel range, where the steep plane drives the depth into both clamps.
    write_triangle(pack_vertex(0, 0, 4096), pack_vertex(0, 256, 8192),
                   pack_vertex(256, 0, -4096));
    send_pixel(0, 0);
    send_pixel(128, 128);
    send_pixel(64, 64);
    send_pixel(-1, 0);
    send_pixel(300, 300);
    send_pixel(32767, 32767);
    send_pixel(-32768, -32768);
    drain_results();

    // A tiny triangle whose normal z component is 21, so most quotients are
    // inexact; negative ones show truncation toward zero rather than floor.
    write_triangle(pack_vertex(0, 0, 0), pack_vertex(0, 3, 5), pack_vertex(7, 0, -3));
    send_pixel(1, 0);
    send_pixel(0, 1);
    send_pixel(5, -2);
    send_pixel(-3, 4);
    drain_results();

    // Corners and depths at the extremes of their fields.
    write_triangle(pack_vertex(-32768, -32768, -32768), pack_vertex(-32768, 32767, 32767),
                   pack_vertex(32767, -32768, 32767));
    send_pixel(0, 0);
    send_pixel(32767, 32767);
    send_pixel(-32768, -32768);
    send_pixel(32767, -32768);
    drain_results();

    // The right triangle again with the opposite winding: nothing is covered,
    // but the depth still follows the plane.
    write_triangle(pack_vertex(0, 0, 4096), pack_vertex(256, 0, -4096),
                   pack_vertex(0, 256, 8192));
    send_pixel(64, 64);
    send_pixel(0, 0);
    drain_results();

    // Three distinct but collinear corners are degenerate as well.
    write_triangle(pack_vertex(0, 0, 100), pack_vertex(16, 16, 200), pack_vertex(32, 32, 300));
    send_pixel(16, 16);
    drain_results();

    // Random part. Each triangle gets its own sender burst profile and its
    // own receiver stall mode; about a quarter of them run the sender with no
    // gaps at all. The stream is drained before every register reload, which
    // also makes the sender wait out the pipeline many times over.
    for (int t = 0; t < RANDOM_TRIANGLES; t++) begin
      make_random_triangle();
      write_triangle(pack_vertex(corner_x[0], corner_y[0], corner_z[0]),
                     pack_vertex(corner_x[1], corner_y[1], corner_z[1]),
                     pack_vertex(corner_x[2], corner_y[2], corner_z[2]));
      ready_mode    <= ready_mode_t'($urandom_range(0, 3));
      stall_pattern <= 12'($urandom_range(1, 4095));
      gap_max    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      n_items    = $urandom_range(16, 44);
      burst_left = $urandom_range(1, 12);
      for (int k = 0; k < n_items; k++) begin
        pick_pixel(px, py);
        send_pixel(px, py);
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap        = $urandom_range(0, gap_max);
          if (gap > 0) pixel_idle(gap);
        end
      end
      drain_results();
    end

    // Give a misbehaving block time to emit anything extra.
    ready_mode <= READY_ALWAYS;
    repeat (PIPE_LATENCY + 8) @(posedge clk);

    $display("Summary: %0d pixel results checked over %0d triangle loads (%0d random).",
             sb.checked, setups, RANDOM_TRIANGLES);
    $display("Summary: %0d covered, %0d degenerate, %0d clamped depths, %0d mismatches.",
             sb.covered_predicted, sb.degenerate_predicted, sb.saturated_predicted,
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("tb_triangle_pixel_coverage_depth passed");
    end else begin
      $display("tb_triangle_pixel_coverage_depth failed");
    end
    $finish;
  end

endmodule

// ===== triangle_pixel_coverage_depth.f =====
sv/tpcd_pkg.sv
sv/tpcd_pixel_if.sv
sv/tpcd_result_if.sv
sv/tpcd_front.sv
sv/tpcd_div.sv
sv/tpcd_out.sv
sv/triangle_pixel_coverage_depth.sv
sim/tb_triangle_pixel_coverage_depth.sv
